// ----- rtl/core/xfpr_pkg.sv -----
// Shared types and constants of the XOR framed packet receiver.
// No dependencies; the front, queue, back and top files refer to it by scoped names.
package xfpr_pkg;

   // Parser phases, one-hot
   typedef enum logic [6:0] {
      PH_HUNT    = 7'b0000001,
      PH_CMD     = 7'b0000010,
      PH_LEN     = 7'b0000100,
      PH_SEQLO   = 7'b0001000,
      PH_SEQHI   = 7'b0010000,
      PH_PAYLOAD = 7'b0100000,
      PH_CHECK   = 7'b1000000
   } phase_type;

   typedef logic [1:0] status_type;
   localparam status_type ST_OK         = 2'd0;
   localparam status_type ST_OVERLENGTH = 2'd1;
   localparam status_type ST_BADSUM     = 2'd2;

   // Configuration register indexes
   localparam logic [7:0] CSR_SYNC       = 8'd0;
   localparam logic [7:0] CSR_REPLY_SYNC = 8'd1;
   localparam logic [7:0] CSR_MAX_LENGTH = 8'd2;
   localparam logic [7:0] CSR_TIMEOUT    = 8'd3;

   // Configuration reset values
   localparam logic [7:0] SYNC_RESET       = 8'hA5;
   localparam logic [7:0] REPLY_SYNC_RESET = 8'h5A;
   localparam logic [7:0] MAX_LENGTH_RESET = 8'd32;
   localparam logic [7:0] TIMEOUT_RESET    = 8'd30;

   localparam logic [7:0] IDLE_MAX = 8'hFF;

   // Reply beat positions
   typedef logic [1:0] beat_type;
   localparam beat_type BEAT_SYNC   = 2'd0;
   localparam beat_type BEAT_SEQLO  = 2'd1;
   localparam beat_type BEAT_SEQHI  = 2'd2;
   localparam beat_type BEAT_STATUS = 2'd3;

   // One queued reply
   typedef struct packed {
      logic [7:0]  rsync;
      logic [15:0] seq;
      status_type  status;
   } reply_type;

   // Queue side of the front/back hand-off
   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

endpackage

// ----- rtl/core/xfpr_if.sv -----
// Channel interfaces of the XOR framed packet receiver: request, reply, register write.
// Stand-alone; no package needed.
interface xfpr_req_if;
   logic       valid;
   logic       ready;
   logic       action;
   logic [7:0] data_byte;
   modport source (output valid, action, data_byte, input ready);
   modport sink   (input valid, action, data_byte, output ready);
endinterface

interface xfpr_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] reply_byte;
   logic       reply_last;
   modport source (output valid, reply_byte, reply_last, input ready);
   modport sink   (input valid, reply_byte, reply_last, output ready);
endinterface

interface xfpr_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] reg_index;
   logic [7:0] wdata;
   modport source (output valid, reg_index, wdata, input ready);
   modport sink   (input valid, reg_index, wdata, output ready);
endinterface

// ----- rtl/core/xfpr_front.sv -----
// Front end: configuration registers, packet parser and idle timer.
// Uses xfpr_pkg and the request and register-write interfaces.
module xfpr_front (
   input  logic                clock,
   input  logic                reset,
   xfpr_req_if.sink            req_bus,
   xfpr_csr_if.sink            csr_bus,
   input  xfpr_pkg::qstat_type qstat,
   output logic                push,
   output xfpr_pkg::reply_type push_data
);

   logic [7:0] sync_ff, rsync_ff, maxlen_ff, timeout_ff;
   xfpr_pkg::phase_type phase_ff, phase_in;
   logic [7:0]  len_ff, len_in;
   logic [15:0] seq_ff, seq_in;
   logic [7:0]  xor_ff, xor_in;
   logic [7:0]  cnt_ff, cnt_in;
   logic [7:0]  idle_ff, idle_in;
   logic [7:0]  idle_sat;
   logic [7:0]  cnt_next;
   logic        accept;
   logic        csr_accept;
   xfpr_pkg::status_type status;
   logic [7:0]  b;

   assign req_bus.ready = !qstat.full;
   assign accept        = req_bus.valid && req_bus.ready;
   assign csr_bus.ready = 1'b1;
   assign csr_accept    = csr_bus.valid && csr_bus.ready;
   assign b             = req_bus.data_byte;
   assign idle_sat      = (idle_ff == xfpr_pkg::IDLE_MAX) ? idle_ff : idle_ff + 8'd1;
   assign cnt_next      = cnt_ff + 8'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_ff    <= xfpr_pkg::SYNC_RESET;
         rsync_ff   <= xfpr_pkg::REPLY_SYNC_RESET;
         maxlen_ff  <= xfpr_pkg::MAX_LENGTH_RESET;
         timeout_ff <= xfpr_pkg::TIMEOUT_RESET;
      end else if (csr_accept) begin
         unique case (csr_bus.reg_index)
            xfpr_pkg::CSR_SYNC:       sync_ff    <= csr_bus.wdata;
            xfpr_pkg::CSR_REPLY_SYNC: rsync_ff   <= csr_bus.wdata;
            xfpr_pkg::CSR_MAX_LENGTH: maxlen_ff  <= csr_bus.wdata;
            xfpr_pkg::CSR_TIMEOUT:    timeout_ff <= csr_bus.wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      phase_in = phase_ff;
      len_in   = len_ff;
      seq_in   = seq_ff;
      xor_in   = xor_ff;
      cnt_in   = cnt_ff;
      idle_in  = idle_ff;
      push     = 1'b0;
      status   = xfpr_pkg::ST_OK;
      if (accept) begin
         if (req_bus.action) begin
            // tick: count idle time, drop a stalled packet
            idle_in = idle_sat;
            if (phase_ff != xfpr_pkg::PH_HUNT && idle_sat > timeout_ff) begin
               phase_in = xfpr_pkg::PH_HUNT;
               xor_in   = 8'd0;
               cnt_in   = 8'd0;
            end
         end else begin
            idle_in = 8'd0;
            unique case (phase_ff)
               xfpr_pkg::PH_CMD: begin
                  xor_in   = b;
                  phase_in = xfpr_pkg::PH_LEN;
               end
               xfpr_pkg::PH_LEN: begin
                  len_in = b;
                  if (b > maxlen_ff) begin
                     push     = 1'b1;
                     status   = xfpr_pkg::ST_OVERLENGTH;
                     phase_in = xfpr_pkg::PH_HUNT;
                     xor_in   = 8'd0;
                     cnt_in   = 8'd0;
                  end else begin
                     xor_in   = xor_ff ^ b;
                     phase_in = xfpr_pkg::PH_SEQLO;
                  end
               end
               xfpr_pkg::PH_SEQLO: begin
                  seq_in   = {8'd0, b};
                  xor_in   = xor_ff ^ b;
                  phase_in = xfpr_pkg::PH_SEQHI;
               end
               xfpr_pkg::PH_SEQHI: begin
                  seq_in   = {b, seq_ff[7:0]};
                  xor_in   = xor_ff ^ b;
                  cnt_in   = 8'd0;
                  phase_in = (len_ff == 8'd0) ? xfpr_pkg::PH_CHECK : xfpr_pkg::PH_PAYLOAD;
               end
               xfpr_pkg::PH_PAYLOAD: begin
                  cnt_in = cnt_next;
                  xor_in = xor_ff ^ b;
                  if (cnt_next == len_ff) phase_in = xfpr_pkg::PH_CHECK;
               end
               xfpr_pkg::PH_CHECK: begin
                  push     = 1'b1;
                  status   = (b == xor_ff) ? xfpr_pkg::ST_OK : xfpr_pkg::ST_BADSUM;
                  phase_in = xfpr_pkg::PH_HUNT;
                  xor_in   = 8'd0;
                  cnt_in   = 8'd0;
               end
               default: begin
                  // hunt, and any stray code
                  phase_in = (b == sync_ff) ? xfpr_pkg::PH_CMD : xfpr_pkg::PH_HUNT;
               end
            endcase
         end
      end
   end

   assign push_data.rsync  = rsync_ff;
   assign push_data.seq    = seq_ff;
   assign push_data.status = status;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= xfpr_pkg::PH_HUNT;
         len_ff   <= 8'd0;
         seq_ff   <= 16'd0;
         xor_ff   <= 8'd0;
         cnt_ff   <= 8'd0;
         idle_ff  <= 8'd0;
      end else begin
         phase_ff <= phase_in;
         len_ff   <= len_in;
         seq_ff   <= seq_in;
         xor_ff   <= xor_in;
         cnt_ff   <= cnt_in;
         idle_ff  <= idle_in;
      end
   end

   a_check_to_hunt: assert property (@(posedge clock) disable iff (reset)
      accept && !req_bus.action && phase_ff == xfpr_pkg::PH_CHECK
      |=> phase_ff == xfpr_pkg::PH_HUNT && xor_ff == 8'd0)
      else $error("parser did not return to hunt after checksum byte");

endmodule

// ----- rtl/core/xfpr_queue.sv -----
// Reply descriptor queue between parser and reply serializer.
// Uses xfpr_pkg for the descriptor and status types.
module xfpr_queue #(
   parameter int DEPTH = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  xfpr_pkg::reply_type push_data,
   input  logic                pop,
   output xfpr_pkg::reply_type head,
   output xfpr_pkg::qstat_type qstat
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   xfpr_pkg::reply_type slot_ff [DEPTH];
   logic [PW-1:0] wr_ff, rd_ff;
   logic [CW-1:0] count_ff;

   assign qstat.full  = (count_ff == CW'(DEPTH));
   assign qstat.empty = (count_ff == '0);
   assign head        = slot_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (push) wr_ff <= (wr_ff == PW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
         if (pop)  rd_ff <= (rd_ff == PW'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
         if (push && !pop)      count_ff <= count_ff + 1'b1;
         else if (pop && !push) count_ff <= count_ff - 1'b1;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !qstat.full || pop)
      else $error("reply queue overflow");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !qstat.empty)
      else $error("reply queue underflow");

endmodule

// ----- rtl/core/xfpr_back.sv -----
// Back end: serializes each queued reply into four output beats.
// Uses xfpr_pkg and the reply interface.
module xfpr_back (
   input  logic                clock,
   input  logic                reset,
   input  xfpr_pkg::reply_type head,
   input  xfpr_pkg::qstat_type qstat,
   output logic                pop,
   xfpr_rsp_if.source          rsp_bus
);

   xfpr_pkg::reply_type cur_ff;
   xfpr_pkg::beat_type  beat_ff;
   logic                busy_ff;
   logic                out_accept;
   logic                last_beat;

   assign last_beat  = (beat_ff == xfpr_pkg::BEAT_STATUS);
   assign out_accept = rsp_bus.valid && rsp_bus.ready;
   // load the next reply when idle or as the final beat leaves
   assign pop = !qstat.empty && (!busy_ff || (out_accept && last_beat));

   always_ff @(posedge clock) begin
      if (pop) cur_ff <= head;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         beat_ff <= xfpr_pkg::BEAT_SYNC;
      end else if (pop) begin
         busy_ff <= 1'b1;
         beat_ff <= xfpr_pkg::BEAT_SYNC;
      end else if (out_accept) begin
         if (last_beat) busy_ff <= 1'b0;
         beat_ff <= beat_ff + 2'd1;
      end
   end

   always_comb begin
      unique case (beat_ff)
         xfpr_pkg::BEAT_SYNC:   rsp_bus.reply_byte = cur_ff.rsync;
         xfpr_pkg::BEAT_SEQLO:  rsp_bus.reply_byte = cur_ff.seq[7:0];
         xfpr_pkg::BEAT_SEQHI:  rsp_bus.reply_byte = cur_ff.seq[15:8];
         xfpr_pkg::BEAT_STATUS: rsp_bus.reply_byte = {6'd0, cur_ff.status};
         default:               rsp_bus.reply_byte = cur_ff.rsync;
      endcase
   end

   assign rsp_bus.valid      = busy_ff;
   assign rsp_bus.reply_last = last_beat;

   a_last_wraps: assert property (@(posedge clock) disable iff (reset)
      out_accept && last_beat |=> beat_ff == xfpr_pkg::BEAT_SYNC)
      else $error("beat counter did not restart after final reply beat");

endmodule

// ----- rtl/core/xor_framed_packet_receiver.sv -----
// Top level of the XOR framed packet receiver: parser, reply queue, serializer.
// Depends on xfpr_pkg, xfpr_if, xfpr_front, xfpr_queue and xfpr_back.
//
//  channel   dir  payload                 handshake
//  req_bus   in   action, data_byte       valid/ready, beat on valid & ready
//  rsp_bus   out  reply_byte, reply_last  valid/ready, beat on valid & ready
//  csr_bus   in   reg_index, wdata        valid/ready, ready always high
//
// One request beat is taken every cycle while the reply queue has room;
// req_bus.ready drops only when QUEUE_DEPTH replies are waiting.
// A reply's first beat passes a queue slot, then the serializer's register;
// one beat per cycle as rsp_bus.ready allows: four beats per reply.
// Reset is synchronous, active high, and restores the default registers.
// A stall on rsp_bus holds the current beat and backs up the queue, then req_bus.
module xor_framed_packet_receiver #(
   parameter int QUEUE_DEPTH = 4
) (
   input logic         clock,
   input logic         reset,
   xfpr_req_if.sink    req_bus,
   xfpr_rsp_if.source  rsp_bus,
   xfpr_csr_if.sink    csr_bus
);

   logic                push;
   logic                pop;
   xfpr_pkg::reply_type push_data;
   xfpr_pkg::reply_type head;
   xfpr_pkg::qstat_type qstat;

   // Parse request beats, push one descriptor per reply
   xfpr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .csr_bus   (csr_bus),
      .qstat     (qstat),
      .push      (push),
      .push_data (push_data)
   );

   // Decouple parser from the output side
   xfpr_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head      (head),
      .qstat     (qstat)
   );

   // Drain descriptors as four-beat bursts
   xfpr_back u_back (
      .clock   (clock),
      .reset   (reset),
      .head    (head),
      .qstat   (qstat),
      .pop     (pop),
      .rsp_bus (rsp_bus)
   );

endmodule
